FILE: hw/rtl/hwpm_pkg.sv
package hwpm_pkg;

  localparam int NumWires   = 16;
  localparam int WireIdxW   = 4;
  localparam int CondW      = 24;
  localparam int DefCondW   = 23;
  localparam int GsumW      = 27;
  localparam int CtrW       = 8;

  localparam logic [8:0]       RatioFloor = 9'd26;
  localparam logic [8:0]       RatioCeil  = 9'd256;
  localparam logic [4:0]       LimitCap   = 5'd20;
  localparam logic [CtrW-1:0]  CtrMax     = 8'd255;
  localparam logic [CondW-1:0] CondInvalid = 24'd6553600;

  typedef enum logic [1:0] {
    REQ_MEASURE = 2'd0,
    REQ_PROBE   = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_MIN_RATIO = 3'd0,
    CFG_FAIL_LIM  = 3'd1,
    CFG_LEAK      = 3'd2,
    CFG_DEF_COND  = 3'd3,
    CFG_MIN_VBUS  = 3'd4
  } cfg_idx_t;

  // Effective conductance of one table entry (zero or out of range -> default).
  function automatic logic [DefCondW-1:0] wire_cond(input logic [CondW-1:0] g,
                                                    input logic [DefCondW-1:0] dflt);
    logic [DefCondW-1:0] d;
    d = dflt;
    if (d == '0) d = DefCondW'(1);
    if ({1'b0, d} >= CondInvalid) d = DefCondW'(CondInvalid - 24'd1);
    if (g == '0 || g >= CondInvalid) return d;
    return g[DefCondW-1:0];
  endfunction

endpackage

FILE: hw/rtl/heater_wire_presence_monitor.sv
// Heater wire presence monitor. Keeps a presence bit per wire (flops), and a
// conductance table and a fail counter table in two 16-entry synchronous RAMs.
// Each RAM entry has a valid flop; an entry that is not valid reads as zero,
// so an unloaded conductance falls back to the default and a cleared counter
// starts from zero. A measure transaction walks the conductance RAM, runs the
// ratio test in a multiply/compare pipeline, then walks the counter RAM doing
// read-modify-write. A probe reads one conductance entry and runs the same
// ratio test. One transaction is in work at a time; the result sits in an
// output register so the next transaction can be accepted while it waits.
// Clearing the fail counters is a reset of per-entry valid bits. Configuration
// writes take effect immediately.
module heater_wire_presence_monitor
  import hwpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_wire_mask,
  input  logic [15:0] in_overtemp_mask,
  input  logic [15:0] in_bus_voltage_mv,
  input  logic signed [17:0] in_current_ma,
  input  logic        in_sample_valid,
  input  logic [4:0]  in_wire_index,
  input  logic        in_access_allowed,
  input  logic [23:0] in_wire_conductance,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_presence_mask,
  output logic        out_changed,
  output logic        out_evaluated,
  output logic        out_ratio_failed
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_PRB  = 6'b000100,
    ST_MATH = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  // configuration registers
  logic [8:0]          min_ratio_r;
  logic [4:0]          fail_lim_r;
  logic [23:0]         leak_r;
  logic [DefCondW-1:0] def_cond_r;
  logic [15:0]         min_vbus_r;

  // memories
  logic [CondW-1:0] cond_mem [NumWires];
  logic [CtrW-1:0]  ctr_mem  [NumWires];
  logic [CondW-1:0] cond_rd_r;
  logic [CtrW-1:0]  ctr_rd_r;
  logic [WireIdxW-1:0] rd_addr;

  // control / datapath
  state_t               state_r, state_nxt;
  logic [NumWires-1:0]  present_r;
  logic [NumWires-1:0]  ctr_vld_r;
  logic [NumWires-1:0]  cond_vld_r;
  logic [WireIdxW-1:0]  cnt_r;
  logic [WireIdxW-1:0]  wsel_r;
  logic                 is_probe_r;
  logic [NumWires-1:0]  elig_r;
  logic [15:0]          v_r;
  logic [17:0]          cur_abs_r;
  logic [GsumW-1:0]     gsum_r;
  logic [39:0]          leak_cur_r;
  logic [24:0]          rv_r;
  logic [41:0]          wire_r;
  logic [51:0]          exp_r;
  logic                 changed_r, eval_r, fail_r;

  logic                 out_valid_r;
  logic [15:0]          out_mask_r;
  logic                 out_changed_r, out_eval_r, out_fail_r;

  // effective settings
  logic [8:0] eff_ratio;
  logic [4:0] eff_lim;
  always_comb begin
    eff_ratio = min_ratio_r;
    if (eff_ratio < RatioFloor) eff_ratio = RatioFloor;
    if (eff_ratio > RatioCeil)  eff_ratio = RatioCeil;
    eff_lim = fail_lim_r;
    if (eff_lim == '0)      eff_lim = 5'd1;
    if (eff_lim > LimitCap) eff_lim = LimitCap;
  end

  logic in_acc, out_free;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // transaction decode at accept
  logic [17:0]         in_abs;
  logic                sample_ok, idx_ok;
  logic [WireIdxW-1:0] in_w;
  logic [NumWires-1:0] in_elig;
  assign in_abs    = in_current_ma[17] ? 18'(-in_current_ma) : 18'(in_current_ma);
  assign sample_ok = in_sample_valid && (in_bus_voltage_mv > min_vbus_r);
  assign idx_ok    = (in_wire_index >= 5'd1) && (in_wire_index <= 5'(NumWires));
  assign in_w      = WireIdxW'(in_wire_index - 5'd1);
  assign in_elig   = (in_wire_mask[NumWires-1:0] & present_r & ~in_overtemp_mask[NumWires-1:0]);

  // counter update for the current walk entry
  logic [CtrW-1:0] ctr_cur, ctr_inc;
  assign ctr_cur = ctr_vld_r[cnt_r] ? ctr_rd_r : '0;
  assign ctr_inc = (ctr_cur == CtrMax) ? CtrMax : ctr_cur + CtrW'(1);

  // shared read address for both RAMs
  always_comb begin
    rd_addr = cnt_r + WireIdxW'(1);
    unique case (state_r)
      ST_IDLE: rd_addr = (in_req_type == REQ_PROBE) ? in_w : '0;
      ST_MATH: rd_addr = '0;
      default: rd_addr = cnt_r + WireIdxW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    cond_rd_r <= cond_mem[rd_addr];
    ctr_rd_r  <= ctr_mem[rd_addr];
    if (state_r == ST_IDLE && in_acc && in_req_type == REQ_LOAD && idx_ok) begin
      cond_mem[in_w] <= in_wire_conductance;
    end
    if (state_r == ST_UPD && elig_r[cnt_r]) begin
      ctr_mem[cnt_r] <= fail_r ? ctr_inc : '0;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ratio_r <= 9'd128;
      fail_lim_r  <= 5'd3;
      leak_r      <= 24'd168;
      def_cond_r  <= 23'd65536;
      min_vbus_r  <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RATIO: min_ratio_r <= cfg_wdata[8:0];
        CFG_FAIL_LIM:  fail_lim_r  <= cfg_wdata[4:0];
        CFG_LEAK:      leak_r      <= cfg_wdata;
        CFG_DEF_COND:  def_cond_r  <= cfg_wdata[DefCondW-1:0];
        CFG_MIN_VBUS:  min_vbus_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EMIT;
          if (in_req_type == REQ_MEASURE && in_wire_mask[NumWires-1:0] != '0
              && sample_ok && in_elig != '0) state_nxt = ST_SUM;
          if (in_req_type == REQ_PROBE && idx_ok && in_access_allowed && sample_ok)
            state_nxt = ST_PRB;
        end
      end
      ST_SUM:  if (cnt_r == WireIdxW'(NumWires - 1)) state_nxt = ST_MATH;
      ST_PRB:  state_nxt = ST_MATH;
      ST_MATH: if (cnt_r == WireIdxW'(2)) state_nxt = is_probe_r ? ST_EMIT : ST_UPD;
      ST_UPD:  if (cnt_r == WireIdxW'(NumWires - 1)) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      ctr_vld_r   <= '0;
      cond_vld_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_acc) begin
            if (in_req_type == REQ_CLEAR) ctr_vld_r <= '0;
            if (in_req_type == REQ_LOAD && idx_ok) cond_vld_r[in_w] <= 1'b1;
            if (in_req_type == REQ_PROBE && idx_ok) begin
              ctr_vld_r <= '0;
              if (!(in_access_allowed && sample_ok)) present_r[in_w] <= 1'b0;
            end
          end
        end
        ST_SUM: cnt_r <= (cnt_r == WireIdxW'(NumWires - 1)) ? '0 : cnt_r + WireIdxW'(1);
        ST_PRB: cnt_r <= '0;
        ST_MATH: begin
          cnt_r <= (cnt_r == WireIdxW'(2)) ? '0 : cnt_r + WireIdxW'(1);
          if (cnt_r == WireIdxW'(2) && is_probe_r) present_r[wsel_r] <= !(52'(wire_r) < exp_r);
        end
        ST_UPD: begin
          cnt_r <= cnt_r + WireIdxW'(1);
          if (elig_r[cnt_r]) begin
            ctr_vld_r[cnt_r] <= 1'b1;
            if (fail_r && ctr_inc >= CtrW'(eff_lim)) present_r[cnt_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          is_probe_r <= (in_req_type == REQ_PROBE);
          wsel_r     <= in_w;
          elig_r     <= in_elig;
          v_r        <= in_bus_voltage_mv;
          cur_abs_r  <= in_abs;
          gsum_r     <= '0;
          changed_r  <= 1'b0;
          eval_r     <= 1'b0;
          fail_r     <= 1'b0;
        end
      end
      ST_SUM: begin
        if (elig_r[cnt_r])
          gsum_r <= gsum_r + GsumW'(wire_cond(cond_vld_r[cnt_r] ? cond_rd_r : '0, def_cond_r));
      end
      ST_PRB: gsum_r <= GsumW'(wire_cond(cond_vld_r[wsel_r] ? cond_rd_r : '0, def_cond_r));
      ST_MATH: begin
        // 0: leak current and ratio*V; 1: wire current and required current; 2: compare
        if (cnt_r == WireIdxW'(0)) begin
          leak_cur_r <= 40'(v_r) * 40'(leak_r);
          rv_r       <= 25'(eff_ratio) * 25'(v_r);
        end
        if (cnt_r == WireIdxW'(1)) begin
          wire_r <= ({cur_abs_r, 24'd0} > 42'(leak_cur_r)) ?
                    {cur_abs_r, 24'd0} - 42'(leak_cur_r) : '0;
          exp_r  <= 52'(rv_r) * 52'(gsum_r);
        end
        if (cnt_r == WireIdxW'(2)) begin
          eval_r <= 1'b1;
          fail_r <= (52'(wire_r) < exp_r);
        end
      end
      ST_UPD: begin
        if (elig_r[cnt_r] && fail_r && ctr_inc >= CtrW'(eff_lim)) changed_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_mask_r    <= 16'(present_r);
      out_changed_r <= changed_r;
      out_eval_r    <= eval_r;
      out_fail_r    <= fail_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_presence_mask = out_mask_r;
  assign out_changed       = out_changed_r;
  assign out_evaluated     = out_eval_r;
  assign out_ratio_failed  = out_fail_r;

endmodule

FILE: bench/tb_heater_wire_presence_monitor.sv
`timescale 1ns / 100ps

// Presence monitor bench: queued transactions are driven through the valid/stall
// input channel, an in-bench model of the wire state predicts each result, and
// the monitor compares every result field against the oldest prediction.
module tb_heater_wire_presence_monitor;
  import hwpm_pkg::*;

  typedef struct packed {
    req_t         req;
    logic [15:0]  mask;
    logic [15:0]  otmp;
    logic [15:0]  vbus;
    logic [17:0]  cur;
    logic         sval;
    logic [4:0]   idx;
    logic         acc;
    logic [23:0]  gload;
  } txn_t;

  typedef struct packed {
    logic [15:0] pres;
    logic        chg;
    logic        evl;
    logic        fail;
  } res_t;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [15:0] in_wire_mask = '0, in_overtemp_mask = '0, in_bus_voltage_mv = '0;
  logic signed [17:0] in_current_ma = '0;
  logic in_sample_valid = 1'b0, in_access_allowed = 1'b0;
  logic [4:0] in_wire_index = '0;
  logic [23:0] in_wire_conductance = '0;
  logic out_valid, out_stall = 1'b0;
  logic [15:0] out_presence_mask;
  logic out_changed, out_evaluated, out_ratio_failed;

  heater_wire_presence_monitor DUT (.*);

  initial forever #2 clk = ~clk;

  // predictor state and configuration copy
  logic [8:0]  m_ratio;
  logic [4:0]  m_limit;
  logic [23:0] m_leak;
  logic [22:0] m_dflt;
  logic [15:0] m_vmin;
  logic [15:0] m_present;
  logic [7:0]  m_ctr [16];
  logic [23:0] m_gtab [16];

  txn_t pending_txns[$];
  res_t expected_results[$];
  int errors = 0;
  int idle_send = 0, idle_recv = 0;   // percent idling per side
  int quiet_cycles = 0;

  function automatic logic [63:0] eff_cond(int w);
    logic [63:0] g, d;
    g = m_gtab[w];
    d = m_dflt;
    if (d == 0) d = 1;
    if (d >= 6553600) d = 6553599;
    if (g == 0 || g >= 6553600) g = d;
    return g;
  endfunction

  // exact ratio test by cross multiplication, true on failure
  function automatic logic below_ratio(logic [15:0] v, logic [17:0] cur, logic [63:0] gsum);
    logic [63:0] ca, meas, lk, wcur, expc, r;
    ca = cur[17] ? 64'(18'h0 - cur) : 64'(cur);
    if (cur[17]) ca = 64'h40000 - 64'(cur);
    meas = ca << 24;
    lk = 64'(v) * 64'(m_leak);
    wcur = meas > lk ? meas - lk : 64'd0;
    expc = (64'(v) * gsum) << 8;
    r = m_ratio < 26 ? 64'd26 : (m_ratio > 256 ? 64'd256 : 64'(m_ratio));
    return (wcur << 8) < r * expc;
  endfunction

  function automatic res_t predict_presence(txn_t t);
    res_t r;
    logic [15:0] elig;
    logic [63:0] gsum;
    logic ok, f;
    int lim, w;
    r = '0;
    elig = '0;
    gsum = 0;
    ok = t.sval && t.vbus > m_vmin;
    lim = m_limit < 1 ? 1 : (m_limit > 20 ? 20 : m_limit);
    case (t.req)
      REQ_MEASURE: begin
        if (t.mask != 0 && ok)
          for (int i = 0; i < 16; i++)
            if (t.mask[i] && m_present[i] && !t.otmp[i]) begin
              elig[i] = 1'b1;
              gsum += eff_cond(i);
            end
        if (elig != 0) begin
          f = below_ratio(t.vbus, t.cur, gsum);
          r.evl = 1'b1;
          r.fail = f;
          for (int i = 0; i < 16; i++) begin
            if (!elig[i]) continue;
            if (f) begin
              if (m_ctr[i] < 255) m_ctr[i]++;
              if (m_ctr[i] >= lim) begin
                m_present[i] = 1'b0;
                r.chg = 1'b1;
              end
            end else m_ctr[i] = 0;
          end
        end
      end
      REQ_PROBE: begin
        if (t.idx >= 1 && t.idx <= 16) begin
          w = t.idx - 1;
          foreach (m_ctr[i]) m_ctr[i] = 0;
          m_present[w] = 1'b0;
          if (t.acc && ok) begin
            f = below_ratio(t.vbus, t.cur, eff_cond(w));
            r.evl = 1'b1;
            r.fail = f;
            m_present[w] = !f;
          end
        end
      end
      REQ_LOAD: if (t.idx >= 1 && t.idx <= 16) m_gtab[t.idx - 1] = t.gload;
      default: foreach (m_ctr[i]) m_ctr[i] = 0;
    endcase
    r.pres = m_present;
    return r;
  endfunction

  // driver: next transaction goes out when the current one is taken (or none held)
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_txns.size() != 0 && $urandom_range(99) >= idle_send) begin
          txn_t t;
          t = pending_txns.pop_front();
          expected_results.push_back(predict_presence(t));
          in_valid <= 1'b1;
          in_req_type <= t.req;
          in_wire_mask <= t.mask;
          in_overtemp_mask <= t.otmp;
          in_bus_voltage_mv <= t.vbus;
          in_current_ma <= t.cur;
          in_sample_valid <= t.sval;
          in_wire_index <= t.idx;
          in_access_allowed <= t.acc;
          in_wire_conductance <= t.gload;
        end else in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < idle_recv);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_presence_mask !== e.pres) begin
            $error("presence_mask exp %h got %h", e.pres, out_presence_mask);
            errors++;
          end
          if (out_changed !== e.chg) begin
            $error("changed exp %b got %b", e.chg, out_changed);
            errors++;
          end
          if (out_evaluated !== e.evl) begin
            $error("evaluated exp %b got %b", e.evl, out_evaluated);
            errors++;
          end
          if (out_ratio_failed !== e.fail) begin
            $error("ratio_failed exp %b got %b", e.fail, out_ratio_failed);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t r, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_MIN_RATIO: m_ratio = val[8:0];
      CFG_FAIL_LIM:  m_limit = val[4:0];
      CFG_LEAK:      m_leak = val;
      CFG_DEF_COND:  m_dflt = val[22:0];
      default:       m_vmin = val[15:0];
    endcase
  endtask

  task automatic drain_all();
    while (pending_txns.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic txn_t blank_txn(req_t rq);
    txn_t t;
    t = '0;
    t.req = rq;
    t.sval = 1'b1;
    t.vbus = 16'd12000;
    return t;
  endfunction

  // current near the expected current of the given conductance sum at vbus
  function automatic logic [17:0] near_current(logic [15:0] v, int gsum);
    longint c;
    c = (longint'(v) * gsum) >>> 16;
    c = c * $urandom_range(160, 20) / 100;
    if (c > 100000) c = 100000;
    if ($urandom_range(1)) c = -c;
    return 18'(c);
  endfunction

  function automatic txn_t random_txn();
    txn_t t;
    int k;
    t = blank_txn(REQ_MEASURE);
    t.mask = 16'($urandom());
    t.otmp = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom()) & 16'($urandom());
    t.vbus = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(24000, 4000));
    t.sval = $urandom_range(15) != 0;
    t.idx = $urandom_range(7) == 0 ? 5'($urandom()) : 5'($urandom_range(16, 1));
    t.acc = $urandom_range(5) != 0;
    t.gload = $urandom_range(3) == 0 ? 24'($urandom()) : 24'($urandom_range(200000, 20000));
    k = $urandom_range(99);
    if (k < 55) t.req = REQ_MEASURE;
    else if (k < 80) t.req = REQ_PROBE;
    else if (k < 92) t.req = REQ_LOAD;
    else t.req = REQ_CLEAR;
    if ($urandom_range(7) == 0) t.cur = 18'($urandom_range(200000) - 100000);
    else t.cur = near_current(t.vbus, (t.req == REQ_PROBE ? 1 : $urandom_range(4, 1)) * 65536);
    return t;
  endfunction

  initial begin
    txn_t t;
    m_ratio = 128; m_limit = 3; m_leak = 168; m_dflt = 65536; m_vmin = 5000;
    m_present = '0;
    foreach (m_ctr[i]) begin
      m_ctr[i] = 0;
      m_gtab[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: loads, probes at extremes, measure early exits, clears
    t = blank_txn(REQ_LOAD); t.idx = 1; t.gload = 24'hFFFFFF; pending_txns.push_back(t);
    t = blank_txn(REQ_LOAD); t.idx = 16; t.gload = 24'd6553599; pending_txns.push_back(t);
    t = blank_txn(REQ_LOAD); t.idx = 0; t.gload = 24'd100; pending_txns.push_back(t);
    t = blank_txn(REQ_LOAD); t.idx = 17; t.gload = 24'd100; pending_txns.push_back(t);
    for (int w = 1; w <= 16; w++) begin
      t = blank_txn(REQ_PROBE); t.idx = 5'(w); t.acc = 1'b1;
      t.cur = (w == 16) ? 18'sh20000 + 18'd31072 : 18'd1000;  // -100000 on wire 16, else 1000
      if (w == 16) t.vbus = 16'hFFFF;
      pending_txns.push_back(t);
    end
    t = blank_txn(REQ_PROBE); t.idx = 2; t.acc = 1'b0; pending_txns.push_back(t);
    t = blank_txn(REQ_MEASURE); t.mask = 0; pending_txns.push_back(t);
    t = blank_txn(REQ_MEASURE); t.mask = 16'hFFFF; t.sval = 0; pending_txns.push_back(t);
    t = blank_txn(REQ_MEASURE); t.mask = 16'hFFFF; t.vbus = 5000; pending_txns.push_back(t);
    t = blank_txn(REQ_MEASURE); t.mask = 16'hFFFF; t.otmp = 16'hFFFF; pending_txns.push_back(t);
    for (int n = 0; n < 3; n++) begin
      t = blank_txn(REQ_MEASURE); t.mask = 16'hFFFF; t.cur = 0; pending_txns.push_back(t);
    end
    t = blank_txn(REQ_CLEAR); pending_txns.push_back(t);
    drain_all();

    // random phases, each with its own register setting and one of four idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_send = 0; idle_recv = 0; end
        1: begin idle_send = 63; idle_recv = 0; end
        2: begin idle_send = 0; idle_recv = 63; end
        default: begin idle_send = 35; idle_recv = 35; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_MIN_RATIO, 26); write_reg(CFG_FAIL_LIM, 1);
          write_reg(CFG_LEAK, 0); write_reg(CFG_DEF_COND, 1); write_reg(CFG_MIN_VBUS, 0);
        end
        1: begin
          write_reg(CFG_MIN_RATIO, 256); write_reg(CFG_FAIL_LIM, 20);
          write_reg(CFG_LEAK, 24'hFFFFFF); write_reg(CFG_DEF_COND, 6553599);
          write_reg(CFG_MIN_VBUS, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_MIN_RATIO, 9'h1FF); write_reg(CFG_FAIL_LIM, 0);
          write_reg(CFG_DEF_COND, 23'h7FFFFF); write_reg(CFG_LEAK, 168);
          write_reg(CFG_MIN_VBUS, 5000);
        end
        3: begin
          write_reg(CFG_MIN_RATIO, 0); write_reg(CFG_FAIL_LIM, 31);
          write_reg(CFG_DEF_COND, 0);
        end
        default: begin
          write_reg(CFG_MIN_RATIO, 24'($urandom_range(256, 26)));
          write_reg(CFG_FAIL_LIM, 24'($urandom_range(6, 1)));
          write_reg(CFG_LEAK, 24'($urandom_range(2000)));
          write_reg(CFG_DEF_COND, 24'($urandom_range(300000, 1)));
          write_reg(CFG_MIN_VBUS, 24'($urandom_range(6000)));
        end
      endcase
      for (int n = 0; n < 200; n++) pending_txns.push_back(random_txn());
      drain_all();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
